### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### src/lgge_pkg.sv
package lgge_pkg;

   // width of the row and column count registers
   localparam int DIM_W = 7;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   // stream payload widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int CELL_IDX_W  = 6;

   // request tdata field positions
   localparam int ROW_LSB = 0;
   localparam int COL_LSB = 6;
   localparam int VAL_BIT = 12;

   // response tdata field positions
   localparam int RD_BIT   = 0;
   localparam int EDGE_BIT = 1;

   // register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_GEN   = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ACCESS = 6'b000100,
      ST_PRIME  = 6'b001000,
      ST_SWEEP  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

endpackage

### src/life_grid_generation_engine_top.sv
// life grid generation engine: a bit grid of cells stepped under the b3/s23 rule
//
// req channel: one beat is one command, req_tuser holds the kind (write cell,
// read cell, advance one generation, or an unused code that does nothing).
// rsp channel: exactly one beat per command, carrying the cell value after the
// access (zero for a generation) and the border flag as it stands afterwards.
// csr port: csr_we with csr_addr selects active_rows (0) or active_cols (1).
//
// an access inside the active area goes through ST_ACCESS and ST_DONE to its
// response beat, one outside it or an unused code straight to ST_DONE, and a
// generation through ST_PRIME, ST_SWEEP over the active rows and ST_DONE; with
// rsp_tready high the next command is taken on the edge the response beat
// leaves. the grid lives in a one-write, one-read memory of a row word per
// entry; a generation streams it a row word per cycle through a three-row window
// and one row-wide rule evaluator. req_tready stays low while a command is busy.
//
// reset: a clearing pass writes every row to zero, with req_tready low
// throughout; the border flag clears and both counts go to 64. a stalled rsp
// beat is held in the output register; the next command may be accepted
// meanwhile, but its result waits until the held beat is taken.
module life_grid_generation_engine_top #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [5:0] cell_row, [11:6] cell_col, [12] cell_value, [15:13] zero
   input  logic [lgge_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  logic [lgge_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] read_value, [1] edge_alive, [7:2] zero
   output logic [lgge_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic                               csr_addr,
   input  logic [lgge_pkg::DIM_W-1:0]         csr_wdata
);

   // address and count widths
   localparam int RAW = $clog2(MAX_ROWS);
   localparam int RW1 = $clog2(MAX_ROWS + 1);
   localparam int CAW = $clog2(MAX_COLS);
   localparam int CW1 = $clog2(MAX_COLS + 1);
   localparam int RCW = (RW1 > lgge_pkg::DIM_W) ? RW1 : lgge_pkg::DIM_W;
   localparam int CCW = (CW1 > lgge_pkg::DIM_W) ? CW1 : lgge_pkg::DIM_W;
   localparam int AXW = RW1 + lgge_pkg::CELL_IDX_W;
   localparam int CXW = CW1 + lgge_pkg::CELL_IDX_W;
   localparam int IXW = RW1 + 1;

   // grid memory, one row word per entry
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];

   logic                mem_we;
   logic [RAW-1:0]      mem_waddr;
   logic [MAX_COLS-1:0] mem_wdata;
   logic                mem_re;
   logic [RAW-1:0]      mem_raddr;
   logic [MAX_COLS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= grid_mem[mem_raddr];
      end
   end

   // control and datapath registers
   lgge_pkg::state_type          state_ff, state_in;
   logic [lgge_pkg::DIM_W-1:0]   rows_cfg_ff, rows_cfg_in;
   logic [lgge_pkg::DIM_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [RAW-1:0]               row_idx_ff, row_idx_in;
   logic [RAW-1:0]               acc_row_ff, acc_row_in;
   logic [CAW-1:0]               acc_col_ff, acc_col_in;
   logic                         acc_val_ff, acc_val_in;
   logic                         acc_write_ff, acc_write_in;
   logic [MAX_COLS-1:0]          prev_ff, prev_in;
   logic [MAX_COLS-1:0]          cur_ff, cur_in;
   logic                         edge_acc_ff, edge_acc_in;
   logic                         border_ff, border_in;
   logic                         res_value_ff, res_value_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_value_ff, rsp_value_in;
   logic                         rsp_edge_ff, rsp_edge_in;

   // clamped active dimensions
   logic [RCW-1:0] rows_ext;
   logic [CCW-1:0] cols_ext;
   logic [RW1-1:0] nr;
   logic [CW1-1:0] nc;
   logic [CW1-1:0] nc_m1;

   always_comb begin
      rows_ext = RCW'(rows_cfg_ff);
      cols_ext = CCW'(cols_cfg_ff);
      if (rows_ext == '0) begin
         nr = RW1'(1);
      end else if (rows_ext > RCW'(MAX_ROWS)) begin
         nr = RW1'(MAX_ROWS);
      end else begin
         nr = rows_ext[RW1-1:0];
      end
      if (cols_ext == '0) begin
         nc = CW1'(1);
      end else if (cols_ext > CCW'(MAX_COLS)) begin
         nc = CW1'(MAX_COLS);
      end else begin
         nc = cols_ext[CW1-1:0];
      end
      nc_m1 = nc - CW1'(1);
   end

   // request fields
   lgge_pkg::req_kind_type          req_kind;
   logic [lgge_pkg::CELL_IDX_W-1:0] req_row;
   logic [lgge_pkg::CELL_IDX_W-1:0] req_col;
   logic                            req_val;
   logic [AXW-1:0]                  req_row_x;
   logic [CXW-1:0]                  req_col_x;
   logic                            req_inside;
   logic                            req_fire;

   assign req_kind  = lgge_pkg::req_kind_type'(req_tuser);
   assign req_row   = req_tdata[lgge_pkg::ROW_LSB +: lgge_pkg::CELL_IDX_W];
   assign req_col   = req_tdata[lgge_pkg::COL_LSB +: lgge_pkg::CELL_IDX_W];
   assign req_val   = req_tdata[lgge_pkg::VAL_BIT];
   assign req_row_x = AXW'(req_row);
   assign req_col_x = CXW'(req_col);
   // out-of-area accesses never reach the memory
   assign req_inside = (req_row_x < AXW'(nr)) && (req_col_x < CXW'(nc));
   assign req_tready = (state_ff == lgge_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // sweep position relative to the active rows
   logic [IXW-1:0] idx_x;
   logic [IXW-1:0] idx_p1;
   logic [IXW-1:0] idx_p2;
   logic           has_next;
   logic           has_next2;
   logic           last_row;

   assign idx_x     = IXW'(row_idx_ff);
   assign idx_p1    = idx_x + IXW'(1);
   assign idx_p2    = idx_x + IXW'(2);
   assign has_next  = idx_p1 < IXW'(nr);
   assign has_next2 = idx_p2 < IXW'(nr);
   assign last_row  = idx_p1 == IXW'(nr);

   // row-wide b3/s23 evaluator over the three-row window
   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] pm, cm, nm;
   logic [MAX_COLS-1:0] pm_l, pm_r, cm_l, cm_r, nm_l, nm_r;
   logic [MAX_COLS-1:0] gen_row;
   logic [MAX_COLS-1:0] gen_wdata;
   logic [3:0]          nbr_cnt [MAX_COLS];
   logic                row_edge;

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         col_mask[j] = CXW'(j) < CXW'(nc);
      end
      pm = prev_ff & col_mask;
      cm = cur_ff & col_mask;
      nm = (has_next ? rd_data_ff : '0) & col_mask;
      // bit j of a left-shifted word is the neighbour at column j-1
      pm_l = pm << 1;
      pm_r = pm >> 1;
      cm_l = cm << 1;
      cm_r = cm >> 1;
      nm_l = nm << 1;
      nm_r = nm >> 1;
      for (int j = 0; j < MAX_COLS; j++) begin
         nbr_cnt[j] = 4'(pm_l[j]) + 4'(pm[j]) + 4'(pm_r[j])
                    + 4'(cm_l[j]) + 4'(cm_r[j])
                    + 4'(nm_l[j]) + 4'(nm[j]) + 4'(nm_r[j]);
         gen_row[j] = (nbr_cnt[j] == 4'd3) || (cm[j] && (nbr_cnt[j] == 4'd2));
      end
      gen_row   = gen_row & col_mask;
      // columns beyond the active area keep their stored cells
      gen_wdata = gen_row | (cur_ff & ~col_mask);
      if ((row_idx_ff == '0) || last_row) begin
         row_edge = |gen_row;
      end else begin
         row_edge = gen_row[0] | gen_row[nc_m1[CAW-1:0]];
      end
   end

   // single-cell access on the fetched row word
   logic [MAX_COLS-1:0] acc_wdata;

   always_comb begin
      acc_wdata             = rd_data_ff;
      acc_wdata[acc_col_ff] = acc_val_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      row_idx_in   = row_idx_ff;
      acc_row_in   = acc_row_ff;
      acc_col_in   = acc_col_ff;
      acc_val_in   = acc_val_ff;
      acc_write_in = acc_write_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      edge_acc_in  = edge_acc_ff;
      border_in    = border_ff;
      res_value_in = res_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_edge_in  = rsp_edge_ff;
      mem_we       = 1'b0;
      mem_waddr    = row_idx_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = row_idx_ff;

      if (csr_we) begin
         unique case (csr_addr)
            lgge_pkg::CSR_ROWS: rows_cfg_in = csr_wdata;
            lgge_pkg::CSR_COLS: cols_cfg_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         lgge_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (row_idx_ff == RAW'(MAX_ROWS - 1)) begin
               row_idx_in = '0;
               state_in   = lgge_pkg::ST_IDLE;
            end else begin
               row_idx_in = row_idx_ff + RAW'(1);
            end
         end
         lgge_pkg::ST_IDLE: begin
            if (req_fire) begin
               acc_row_in   = req_row_x[RAW-1:0];
               acc_col_in   = req_col_x[CAW-1:0];
               acc_val_in   = req_val;
               acc_write_in = (req_kind == lgge_pkg::REQ_WRITE);
               res_value_in = 1'b0;
               unique case (req_kind)
                  lgge_pkg::REQ_WRITE, lgge_pkg::REQ_READ: begin
                     if (req_inside) begin
                        mem_re    = 1'b1;
                        mem_raddr = req_row_x[RAW-1:0];
                        state_in  = lgge_pkg::ST_ACCESS;
                     end else begin
                        state_in = lgge_pkg::ST_DONE;
                     end
                  end
                  lgge_pkg::REQ_GEN: begin
                     mem_re      = 1'b1;
                     mem_raddr   = '0;
                     row_idx_in  = '0;
                     edge_acc_in = 1'b0;
                     state_in    = lgge_pkg::ST_PRIME;
                  end
                  default: state_in = lgge_pkg::ST_DONE;
               endcase
            end
         end
         lgge_pkg::ST_ACCESS: begin
            if (acc_write_ff) begin
               mem_we       = 1'b1;
               mem_waddr    = acc_row_ff;
               mem_wdata    = acc_wdata;
               res_value_in = acc_val_ff;
            end else begin
               res_value_in = rd_data_ff[acc_col_ff];
            end
            state_in = lgge_pkg::ST_DONE;
         end
         lgge_pkg::ST_PRIME: begin
            // row 0 has arrived; fetch row 1 while it settles into the window
            prev_in   = '0;
            cur_in    = rd_data_ff;
            mem_re    = has_next;
            mem_raddr = idx_p1[RAW-1:0];
            state_in  = lgge_pkg::ST_SWEEP;
         end
         lgge_pkg::ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = row_idx_ff;
            mem_wdata = gen_wdata;
            prev_in   = cur_ff;
            cur_in    = rd_data_ff;
            mem_re    = has_next2;
            mem_raddr = idx_p2[RAW-1:0];
            if (last_row) begin
               border_in  = edge_acc_ff | row_edge;
               row_idx_in = '0;
               state_in   = lgge_pkg::ST_DONE;
            end else begin
               edge_acc_in = edge_acc_ff | row_edge;
               row_idx_in  = row_idx_ff + RAW'(1);
            end
         end
         lgge_pkg::ST_DONE: begin
            // hand over only once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_edge_in  = border_ff;
               state_in     = lgge_pkg::ST_IDLE;
            end
         end
         default: state_in = lgge_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgge_pkg::ST_CLEAR;
         rows_cfg_ff  <= lgge_pkg::DIM_RESET;
         cols_cfg_ff  <= lgge_pkg::DIM_RESET;
         row_idx_ff   <= '0;
         border_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         row_idx_ff   <= row_idx_in;
         border_ff    <= border_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_row_ff   <= acc_row_in;
      acc_col_ff   <= acc_col_in;
      acc_val_ff   <= acc_val_in;
      acc_write_ff <= acc_write_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      edge_acc_ff  <= edge_acc_in;
      res_value_ff <= res_value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_edge_ff  <= rsp_edge_in;
   end

   // response beat
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                     = '0;
      rsp_tdata[lgge_pkg::RD_BIT]   = rsp_value_ff;
      rsp_tdata[lgge_pkg::EDGE_BIT] = rsp_edge_ff;
   end

endmodule

### src/lgge_checker.sv
`include "assert_macros.svh"

module lgge_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lgge_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one command at a time: ready drops right after a beat is taken
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // reset starts the clearing pass with nothing offered or accepted
   `ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_tready && !rsp_tvalid)

   // a fresh response only comes out of a busy cycle
   `ASSERT_IMPLIES(a_rsp_from_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind life_grid_generation_engine_top lgge_checker u_lgge_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int GRID_DIM = 64;

   // one command beat as the sender sees it
   typedef struct packed {
      lgge_pkg::req_kind_type          kind;
      logic [lgge_pkg::CELL_IDX_W-1:0] row;
      logic [lgge_pkg::CELL_IDX_W-1:0] col;
      logic                            value;
   } cell_cmd_type;

   // what the response beat of one command should carry
   typedef struct packed {
      logic cell_bit;
      logic border_bit;
   } cell_reply_type;

   // dut ports; every input is known from time zero
   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [lgge_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [lgge_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lgge_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_we     = 1'b0;
   logic                             csr_addr   = lgge_pkg::CSR_ROWS;
   logic [lgge_pkg::DIM_W-1:0]       csr_wdata  = '0;

   // commands waiting to go out, and replies the dut still owes us
   cell_cmd_type   cmd_q [$];
   cell_reply_type cell_reply_q [$];

   // shadow of the block: grid, area registers and border flag
   logic [GRID_DIM-1:0]        life_grid [GRID_DIM];
   logic [lgge_pkg::DIM_W-1:0] rows_reg;
   logic [lgge_pkg::DIM_W-1:0] cols_reg;
   logic                       border_flag_m;

   // idling controls, the percentages set per phase by the stimulus process
   int send_gap_pct = 0;
   int stall_pct    = 0;
   int send_gap     = 0;
   int rsp_stall    = 0;

   // bookkeeping
   cell_cmd_type                     bus_cmd;
   cell_reply_type                   want_reply;
   logic [lgge_pkg::REQ_TDATA_W-1:0] req_word;
   int fail_count   = 0;
   int border_hits  = 0;
   int area_changes = 0;
   int kind_tally [4];

   life_grid_generation_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // shadow of the block
   // ------------------------------------------------------------------

   // register value to rows or columns in use: zero counts as one, above the
   // grid counts as the whole grid
   function automatic int eff_dim(input logic [lgge_pkg::DIM_W-1:0] v);
      if (v == 0)
         return 1;
      if (v > GRID_DIM)
         return GRID_DIM;
      return int'(v);
   endfunction

   // one b3/s23 step over the active area, every cell from the old grid;
   // cells beyond the area are neither counted nor touched
   function automatic void advance_generation();
      logic [GRID_DIM-1:0] prior [GRID_DIM];
      int   nr;
      int   nc;
      int   nbrs;
      logic next_bit;
      logic on_rim;
      nr = eff_dim(rows_reg);
      nc = eff_dim(cols_reg);
      on_rim = 1'b0;
      for (int i = 0; i < GRID_DIM; i++)
         prior[i] = life_grid[i];
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            nbrs = 0;
            for (int di = -1; di <= 1; di++)
               for (int dj = -1; dj <= 1; dj++)
                  if ((di != 0 || dj != 0) && i + di >= 0 && i + di < nr &&
                      j + dj >= 0 && j + dj < nc)
                     nbrs += prior[i + di][j + dj];
            if (prior[i][j])
               next_bit = (nbrs == 2 || nbrs == 3);
            else
               next_bit = (nbrs == 3);
            life_grid[i][j] = next_bit;
            if (next_bit && (i == 0 || i == nr - 1 || j == 0 || j == nc - 1))
               on_rim = 1'b1;
         end
      end
      border_flag_m = on_rim;
   endfunction

   // apply one accepted command to the shadow and return the reply it owes
   function automatic cell_reply_type apply_command(input cell_cmd_type c);
      cell_reply_type r;
      logic           in_area;
      in_area = (int'(c.row) < eff_dim(rows_reg)) && (int'(c.col) < eff_dim(cols_reg));
      r.cell_bit = 1'b0;
      case (c.kind)
         lgge_pkg::REQ_WRITE: begin
            if (in_area) begin
               life_grid[c.row][c.col] = c.value;
               r.cell_bit = c.value;
            end
         end
         lgge_pkg::REQ_READ: begin
            if (in_area)
               r.cell_bit = life_grid[c.row][c.col];
         end
         lgge_pkg::REQ_GEN: begin
            advance_generation();
         end
         default: ;
      endcase
      r.border_bit = border_flag_m;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // request driver: pops the command queue, predicts at acceptance
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         // beat taken this edge: the shadow moves on with it
         if (req_tvalid && req_tready) begin
            cell_reply_q.push_back(apply_command(bus_cmd));
            kind_tally[bus_cmd.kind]++;
         end
         // bus free for a new beat (or still empty)
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 && $urandom_range(0, 99) < send_gap_pct) begin
               // idle burst, this one included; send_gap holds the rest of it
               send_gap = $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               bus_cmd = cmd_q.pop_front();
               req_word = '0;
               req_word[lgge_pkg::ROW_LSB +: lgge_pkg::CELL_IDX_W] = bus_cmd.row;
               req_word[lgge_pkg::COL_LSB +: lgge_pkg::CELL_IDX_W] = bus_cmd.col;
               req_word[lgge_pkg::VAL_BIT]                         = bus_cmd.value;
               req_tdata  <= req_word;
               req_tuser  <= bus_cmd.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor: checks each beat against the oldest reply owed,
   // and throttles rsp_tready in random bursts
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cell_reply_q.size() == 0) begin
               $error("response beat with no command outstanding: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want_reply = cell_reply_q.pop_front();
               if (rsp_tdata[lgge_pkg::RD_BIT] !== want_reply.cell_bit) begin
                  $error("read_value: expected %0b, actual %0b",
                         want_reply.cell_bit, rsp_tdata[lgge_pkg::RD_BIT]);
                  fail_count++;
               end
               if (rsp_tdata[lgge_pkg::EDGE_BIT] !== want_reply.border_bit) begin
                  $error("edge_alive: expected %0b, actual %0b",
                         want_reply.border_bit, rsp_tdata[lgge_pkg::EDGE_BIT]);
                  fail_count++;
               end
               if (want_reply.border_bit)
                  border_hits++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   task automatic queue_cmd(input lgge_pkg::req_kind_type kind, input int row,
                            input int col, input int value);
      cell_cmd_type c;
      c.kind  = kind;
      c.row   = row[lgge_pkg::CELL_IDX_W-1:0];
      c.col   = col[lgge_pkg::CELL_IDX_W-1:0];
      c.value = value[0];
      cmd_q.push_back(c);
   endtask

   // sender holds off until every owed reply is back and the bus is empty
   task automatic wait_drained();
      while (cmd_q.size() != 0 || req_tvalid || cell_reply_q.size() != 0)
         @(posedge clock);
   endtask

   // change the active area, only ever with the block idle
   task automatic set_area(input logic [lgge_pkg::DIM_W-1:0] rows_v,
                           input logic [lgge_pkg::DIM_W-1:0] cols_v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_addr  <= lgge_pkg::CSR_ROWS;
      csr_wdata <= rows_v;
      @(posedge clock);
      csr_addr  <= lgge_pkg::CSR_COLS;
      csr_wdata <= cols_v;
      @(posedge clock);
      csr_we    <= 1'b0;
      rows_reg = rows_v;
      cols_reg = cols_v;
      area_changes++;
   endtask

   // mostly seed-step-sample sequences on a small patch so that patterns
   // interact and evolve, with a tenth of plain noise anywhere on the grid
   task automatic random_burst(input int n);
      int target;
      int nr;
      int nc;
      int win_r;
      int win_c;
      int base_r;
      int base_c;
      int k;
      int rr;
      int cc;
      target = cmd_q.size() + n;
      nr = eff_dim(rows_reg);
      nc = eff_dim(cols_reg);
      win_r = (nr < 6) ? nr : 6;
      win_c = (nc < 6) ? nc : 6;
      while (cmd_q.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_cmd(lgge_pkg::req_kind_type'($urandom_range(0, 3)),
                      $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 1));
         end else begin
            base_r = $urandom_range(0, nr - win_r);
            base_c = $urandom_range(0, nc - win_c);
            // seed, mostly live cells
            k = $urandom_range(3, 12);
            for (int i = 0; i < k && cmd_q.size() < target; i++)
               queue_cmd(lgge_pkg::REQ_WRITE, base_r + $urandom_range(0, win_r - 1),
                         base_c + $urandom_range(0, win_c - 1), $urandom_range(0, 3) != 0);
            // let it run
            k = $urandom_range(1, 5);
            for (int i = 0; i < k && cmd_q.size() < target; i++)
               queue_cmd(lgge_pkg::REQ_GEN, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            // look at the patch and just past it
            k = $urandom_range(2, 10);
            for (int i = 0; i < k && cmd_q.size() < target; i++) begin
               rr = base_r + $urandom_range(0, win_r);
               cc = base_c + $urandom_range(0, win_c);
               queue_cmd(lgge_pkg::REQ_READ, (rr > 63) ? 63 : rr, (cc > 63) ? 63 : cc,
                         $urandom_range(0, 1));
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < GRID_DIM; i++)
         life_grid[i] = '0;
      for (int i = 0; i < 4; i++)
         kind_tally[i] = 0;
      rows_reg      = lgge_pkg::DIM_RESET;
      cols_reg      = lgge_pkg::DIM_RESET;
      border_flag_m = 1'b0;

      // reset is applied once, at the start
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset area 64 x 64 ----------------------------------
      // still-life block in the top-left corner keeps the border flag up
      queue_cmd(lgge_pkg::REQ_WRITE, 0, 0, 1);
      queue_cmd(lgge_pkg::REQ_WRITE, 0, 1, 1);
      queue_cmd(lgge_pkg::REQ_WRITE, 1, 0, 1);
      queue_cmd(lgge_pkg::REQ_WRITE, 1, 1, 1);
      // lone cell in the far corner, dies of isolation
      queue_cmd(lgge_pkg::REQ_WRITE, 63, 63, 1);
      // horizontal blinker in the middle
      queue_cmd(lgge_pkg::REQ_WRITE, 31, 30, 1);
      queue_cmd(lgge_pkg::REQ_WRITE, 31, 31, 1);
      queue_cmd(lgge_pkg::REQ_WRITE, 31, 32, 1);
      // unused code with every field bit high: must change nothing
      queue_cmd(lgge_pkg::REQ_NONE, 63, 63, 1);
      queue_cmd(lgge_pkg::REQ_READ, 0, 0, 0);
      queue_cmd(lgge_pkg::REQ_READ, 63, 63, 0);
      queue_cmd(lgge_pkg::REQ_GEN, 0, 0, 0);
      queue_cmd(lgge_pkg::REQ_READ, 30, 31, 0);
      queue_cmd(lgge_pkg::REQ_READ, 31, 30, 0);
      queue_cmd(lgge_pkg::REQ_READ, 63, 63, 0);
      queue_cmd(lgge_pkg::REQ_GEN, 0, 0, 0);
      // break the block: its rest starves, border flag drops
      queue_cmd(lgge_pkg::REQ_WRITE, 0, 0, 0);
      queue_cmd(lgge_pkg::REQ_WRITE, 0, 1, 0);
      queue_cmd(lgge_pkg::REQ_GEN, 0, 0, 0);
      // parked cell, hidden by the next area and back after it
      queue_cmd(lgge_pkg::REQ_WRITE, 40, 40, 1);

      // phase 1: rows register zero clamps to one row, 127 columns to 64
      send_gap_pct = 15;
      stall_pct    = 15;
      set_area(7'd0, 7'd127);
      queue_cmd(lgge_pkg::REQ_READ, 40, 40, 0);   // outside the area reads dead
      queue_cmd(lgge_pkg::REQ_WRITE, 1, 5, 1);    // outside the area is dropped
      random_burst(120);

      // phase 2: 65 rows clamps to the full grid, hidden cell reappears
      send_gap_pct = 0;
      stall_pct    = 0;
      set_area(7'd65, 7'd127);
      queue_cmd(lgge_pkg::REQ_READ, 40, 40, 0);
      queue_cmd(lgge_pkg::REQ_READ, 1, 5, 0);
      random_burst(250);

      // phase 3: small square, clusters fill most of it
      send_gap_pct = 30;
      stall_pct    = 10;
      set_area(7'd8, 7'd8);
      random_burst(250);

      // phase 4: single column, zero columns clamps to one
      send_gap_pct = 10;
      stall_pct    = 30;
      set_area(7'd127, 7'd0);
      random_burst(80);

      // phase 5: a 3 x 5 area, room for a blinker
      send_gap_pct = 20;
      stall_pct    = 20;
      set_area(7'd3, 7'd5);
      random_burst(150);

      // phase 6: two full-width rows, every cell on the border
      send_gap_pct = 5;
      stall_pct    = 40;
      set_area(7'd2, 7'd64);
      random_burst(100);

      // phase 7: a random small area
      send_gap_pct = 15;
      stall_pct    = 15;
      set_area(lgge_pkg::DIM_W'($urandom_range(1, 24)),
               lgge_pkg::DIM_W'($urandom_range(1, 24)));
      random_burst(250);

      // phase 8: back to the full grid, no idling on either side
      send_gap_pct = 0;
      stall_pct    = 0;
      set_area(7'd64, 7'd64);
      random_burst(330);

      // drain, then wait for any stray beat to show up
      wait_drained();
      repeat (16) @(posedge clock);

      $display("covered %0d writes, %0d reads, %0d generations and %0d unused codes",
               kind_tally[lgge_pkg::REQ_WRITE], kind_tally[lgge_pkg::REQ_READ],
               kind_tally[lgge_pkg::REQ_GEN], kind_tally[lgge_pkg::REQ_NONE]);
      $display("over %0d area settings, with %0d replies showing a live border",
               area_changes, border_hits);
      if (fail_count == 0 && cell_reply_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
